### hdl/cfa_pkg.sv
// Package with shared types and codes for the constant folding ALU.
`default_nettype none
package cfa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_MOD = 4'd4, CMD_AND = 4'd5, CMD_OR = 4'd6, CMD_XOR = 4'd7,
    CMD_SHL = 4'd8, CMD_SHR = 4'd9, CMD_NEG = 4'd10, CMD_NOT = 4'd11
  } cmd_e;

  typedef enum logic [2:0] {
    OUT_FOLD = 3'd0, OUT_PASS_A = 3'd1, OUT_PASS_B = 3'd2,
    OUT_EMIT = 3'd3, OUT_DIV0 = 3'd4
  } outcome_e;

  localparam int unsigned DataW = 64;
  localparam int unsigned CmdW = 4;
  localparam int unsigned SizeW = 2;
  localparam int unsigned OutW = 3;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic             a_unsigned;
    logic             result_unsigned;
    logic [SizeW-1:0] result_size;
    logic             fold;
    logic [OutW-1:0]  outcome;
  } job_t;

endpackage
`default_nettype wire

### hdl/cfa_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface cfa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  logic        a_is_const;
  logic        b_is_const;
  logic        a_unsigned;
  logic        result_unsigned;
  logic [1:0]  result_size;
  modport source (output valid, command, operand_a, operand_b, a_is_const, b_is_const,
                  a_unsigned, result_unsigned, result_size, input ready);
  modport sink (input valid, command, operand_a, operand_b, a_is_const, b_is_const,
                a_unsigned, result_unsigned, result_size, output ready);
endinterface

interface cfa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic signed [63:0] value;
  modport source (output valid, outcome, value, input ready);
  modport sink (input valid, outcome, value, output ready);
endinterface
`default_nettype wire

### hdl/cfa_front.sv
// Front part: accepts items and decides fold, pass-through, emit or divide by zero.
`default_nettype none
module cfa_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  cfa_in_if.sink            in_i,
  output cfa_pkg::job_t     job_o,
  output logic              job_valid_o,
  input  wire logic         job_ready_i
);
  cfa_pkg::job_t job_d, job_q;
  logic          valid_q;
  logic          a_zero, a_one, b_zero, b_one;
  logic [2:0]    oc;
  logic          fold;

  assign a_zero = (in_i.operand_a == 64'd0);
  assign a_one  = (in_i.operand_a == 64'd1);
  assign b_zero = (in_i.operand_b == 64'd0);
  assign b_one  = (in_i.operand_b == 64'd1);

  always_comb begin
    oc = cfa_pkg::OUT_EMIT;
    if (in_i.command >= 4'd12) begin
      oc = cfa_pkg::OUT_EMIT;
    end else if (in_i.command == cfa_pkg::CMD_NEG || in_i.command == cfa_pkg::CMD_NOT) begin
      if (in_i.a_is_const) oc = cfa_pkg::OUT_FOLD;
    end else if (in_i.a_is_const && in_i.b_is_const) begin
      oc = cfa_pkg::OUT_FOLD;
      if ((in_i.command == cfa_pkg::CMD_DIV || in_i.command == cfa_pkg::CMD_MOD) && b_zero)
        oc = cfa_pkg::OUT_DIV0;
    end else if (in_i.a_is_const) begin
      case (in_i.command)
        cfa_pkg::CMD_ADD, cfa_pkg::CMD_OR, cfa_pkg::CMD_XOR: begin
          if (a_zero) oc = cfa_pkg::OUT_PASS_B;
        end
        cfa_pkg::CMD_MUL: begin
          if (a_one) oc = cfa_pkg::OUT_PASS_B;
        end
        cfa_pkg::CMD_DIV, cfa_pkg::CMD_MOD, cfa_pkg::CMD_AND,
        cfa_pkg::CMD_SHL, cfa_pkg::CMD_SHR: begin
          if (a_zero) oc = cfa_pkg::OUT_PASS_A;
        end
        default: ;
      endcase
    end else if (in_i.b_is_const) begin
      case (in_i.command)
        cfa_pkg::CMD_ADD, cfa_pkg::CMD_SUB, cfa_pkg::CMD_OR, cfa_pkg::CMD_XOR,
        cfa_pkg::CMD_SHL, cfa_pkg::CMD_SHR: begin
          if (b_zero) oc = cfa_pkg::OUT_PASS_A;
        end
        cfa_pkg::CMD_MUL: begin
          if (b_one) oc = cfa_pkg::OUT_PASS_A;
        end
        cfa_pkg::CMD_DIV: begin
          if (b_zero) oc = cfa_pkg::OUT_DIV0;
          else if (b_one) oc = cfa_pkg::OUT_PASS_A;
        end
        cfa_pkg::CMD_AND: begin
          if (b_zero) oc = cfa_pkg::OUT_PASS_B;
        end
        default: ;
      endcase
    end
  end

  assign fold = (oc == cfa_pkg::OUT_FOLD);

  always_comb begin
    job_d.command         = in_i.command;
    job_d.operand_a       = in_i.operand_a;
    job_d.operand_b       = in_i.operand_b;
    job_d.a_unsigned      = in_i.a_unsigned;
    job_d.result_unsigned = in_i.result_unsigned;
    job_d.result_size     = in_i.result_size;
    job_d.fold            = fold;
    job_d.outcome         = oc;
  end

  assign in_i.ready = !valid_q || job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) job_q <= job_d;
  end

  assign job_o       = job_q;
  assign job_valid_o = valid_q;
endmodule
`default_nettype wire

### hdl/cfa_queue.sv
// Short FIFO that decouples the front part from the back part.
`default_nettype none
module cfa_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfa_pkg::job_t wdata_i,
  input  wire logic          wvalid_i,
  output logic               wready_o,
  output cfa_pkg::job_t      rdata_o,
  output logic               rvalid_o,
  input  wire logic          rready_i
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  cfa_pkg::job_t        mem_q [Depth];
  logic [PtrW-1:0]      wp_q, rp_q;
  logic [PtrW:0]        cnt_q;
  logic                 push, pop;

  assign wready_o = (cnt_q != Depth[PtrW:0]);
  assign rvalid_o = (cnt_q != '0);
  assign push = wvalid_i && wready_o;
  assign pop  = rvalid_o && rready_i;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wdata_i;
  end
endmodule
`default_nettype wire

### hdl/cfa_divider.sv
// Pipelined 64-bit unsigned divider, one quotient bit per stage.
`default_nettype none
module cfa_divider #(
  parameter int unsigned Width = 64,
  parameter int unsigned TagW  = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  input  wire logic [TagW-1:0]  tag_i,
  output logic                  valid_o,
  output logic [Width-1:0]      quot_o,
  output logic [Width-1:0]      rem_o,
  output logic [TagW-1:0]       tag_o
);
  for (genvar s = 0; s < Width; s++) begin : g_stage
    logic [Width-1:0] rem_in, quo_in, dvs_in;
    logic [TagW-1:0]  tag_in;
    logic             vld_in;
    logic [Width-1:0] rem_q, quo_q, dvs_q;
    logic [TagW-1:0]  tag_q;
    logic             vld_q;
    logic [Width:0]   trial;
    logic [Width:0]   diff;

    if (s == 0) begin : g_head
      assign rem_in = '0;
      assign quo_in = dividend_i;
      assign dvs_in = divisor_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_body
      assign rem_in = g_stage[s-1].rem_q;
      assign quo_in = g_stage[s-1].quo_q;
      assign dvs_in = g_stage[s-1].dvs_q;
      assign tag_in = g_stage[s-1].tag_q;
      assign vld_in = g_stage[s-1].vld_q;
    end

    assign trial = {rem_in, quo_in[Width-1]};
    assign diff  = trial - {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[Width]) begin
          rem_q <= diff[Width-1:0];
          quo_q <= {quo_in[Width-2:0], 1'b1};
        end else begin
          rem_q <= trial[Width-1:0];
          quo_q <= {quo_in[Width-2:0], 1'b0};
        end
        dvs_q <= dvs_in;
        tag_q <= tag_in;
      end
    end
  end

  assign valid_o = g_stage[Width-1].vld_q;
  assign quot_o  = g_stage[Width-1].quo_q;
  assign rem_o   = g_stage[Width-1].rem_q;
  assign tag_o   = g_stage[Width-1].tag_q;
endmodule
`default_nettype wire

### hdl/cfa_back.sv
// Back part: computes folded values in a stalling pipeline and narrows them.
`default_nettype none
module cfa_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfa_pkg::job_t job_i,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  cfa_out_if.source          out_o
);
  localparam int unsigned DivLat = cfa_pkg::DataW;
  // Tag: command(4) result_unsigned size(2) outcome(3) na nb
  localparam int unsigned TagW = 12;

  logic                  en;
  logic [63:0]           a, b, ua, ub, simple, prod_lo;
  logic                  na, nb, signed_div;
  logic [TagW-1:0]       tag_in, tag_out;
  logic                  dv_valid;
  logic [63:0]           quot, remd, q_fix, r_fix, raw, narrowed;

  // Output register with one skid entry; the pipeline advances when the skid is empty.
  logic                  skid_v_q, outr_v_q;
  logic [2:0]            skid_oc_q, outr_oc_q;
  logic [63:0]           skid_val_q, outr_val_q;
  logic [2:0]            res_oc;

  assign en = !skid_v_q;
  assign job_ready_o = en;

  assign a  = job_i.operand_a;
  assign b  = job_i.operand_b;
  assign signed_div = !job_i.result_unsigned;
  assign na = signed_div && a[63];
  assign nb = signed_div && b[63];
  assign ua = na ? (64'd0 - a) : a;
  assign ub = nb ? (64'd0 - b) : b;

  always_comb begin
    case (job_i.command)
      cfa_pkg::CMD_ADD: simple = a + b;
      cfa_pkg::CMD_SUB: simple = a - b;
      cfa_pkg::CMD_AND: simple = a & b;
      cfa_pkg::CMD_OR:  simple = a | b;
      cfa_pkg::CMD_XOR: simple = a ^ b;
      cfa_pkg::CMD_SHL: simple = a << b[5:0];
      cfa_pkg::CMD_SHR: simple = job_i.a_unsigned ? (a >> b[5:0])
                                   : 64'($signed(a) >>> b[5:0]);
      cfa_pkg::CMD_NEG: simple = 64'd0 - a;
      cfa_pkg::CMD_NOT: simple = ~a;
      default:          simple = '0;
    endcase
  end

  assign tag_in = {job_i.command, job_i.result_unsigned, job_i.result_size,
                   job_i.outcome, na, nb};

  cfa_divider #(.Width(64), .TagW(TagW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(job_valid_i),
    .dividend_i(ua), .divisor_i(ub), .tag_i(tag_in),
    .valid_o(dv_valid), .quot_o(quot), .rem_o(remd), .tag_o(tag_out)
  );

  // Multiplier: three 32x32 partial products, summed a stage later.
  logic [63:0] mll_q;
  logic [31:0] mlh_q, mhl_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      mll_q <= a[31:0] * b[31:0];
      mlh_q <= 32'(a[31:0] * b[63:32]);
      mhl_q <= 32'(a[63:32] * b[31:0]);
    end
  end
  assign prod_lo = mll_q + {mlh_q + mhl_q, 32'd0};

  // Other results ride alongside the divider; the product joins at the second stage.
  logic [63:0] simple_q;
  logic [3:0]  cmd_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      simple_q <= simple;
      cmd_q    <= job_i.command;
    end
  end
  logic [63:0] mid_sel;
  assign mid_sel = (cmd_q == cfa_pkg::CMD_MUL) ? prod_lo : simple_q;

  logic [63:0] tail_q [1:DivLat-1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q[1] <= mid_sel;
      for (int s = 2; s < DivLat; s++) begin
        tail_q[s] <= tail_q[s-1];
      end
    end
  end

  logic [3:0] t_cmd;
  logic       t_ru, t_na, t_nb;
  logic [1:0] t_size;
  logic [2:0] t_oc;
  assign {t_cmd, t_ru, t_size, t_oc, t_na, t_nb} = tag_out;

  assign q_fix = (t_na != t_nb) ? (64'd0 - quot) : quot;
  assign r_fix = t_na ? (64'd0 - remd) : remd;

  always_comb begin
    case (t_cmd)
      cfa_pkg::CMD_DIV: raw = q_fix;
      cfa_pkg::CMD_MOD: raw = r_fix;
      default:          raw = tail_q[DivLat-1];
    endcase
    case (t_size)
      2'd0:    narrowed = t_ru ? {56'd0, raw[7:0]}  : {{56{raw[7]}}, raw[7:0]};
      2'd1:    narrowed = t_ru ? {48'd0, raw[15:0]} : {{48{raw[15]}}, raw[15:0]};
      2'd2:    narrowed = t_ru ? {32'd0, raw[31:0]} : {{32{raw[31]}}, raw[31:0]};
      default: narrowed = raw;
    endcase
  end
  assign res_oc = t_oc;

  assign out_o.valid   = outr_v_q;
  assign out_o.outcome = outr_oc_q;
  assign out_o.value   = outr_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outr_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!outr_v_q || out_o.ready) begin
        if (skid_v_q) begin
          outr_v_q <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          outr_v_q <= dv_valid;
        end
      end else if (en && dv_valid) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!outr_v_q || out_o.ready) begin
      if (skid_v_q) begin
        outr_oc_q  <= skid_oc_q;
        outr_val_q <= skid_val_q;
      end else begin
        outr_oc_q  <= res_oc;
        outr_val_q <= (res_oc == cfa_pkg::OUT_FOLD) ? narrowed : 64'd0;
      end
    end else if (en && dv_valid) begin
      skid_oc_q  <= res_oc;
      skid_val_q <= (res_oc == cfa_pkg::OUT_FOLD) ? narrowed : 64'd0;
    end
  end
endmodule
`default_nettype wire

### hdl/constant_fold_alu.sv
// Top level of the constant folding ALU.
// Usage: items arrive on in_if (valid/ready); each accepted item yields exactly one
// result on out_if holding an outcome code and the narrowed folded value.
// The front part classifies an item, registers it and places it in a four-entry queue.
// The back part is a stalling pipeline built around a 64-stage restoring divider,
// one quotient bit per stage; products use three 32x32 partial products over two
// stages and ride alongside the divider. Throughput is one item per cycle while the
// receiver keeps ready high. When the receiver stalls, the output register holds its
// result, one more result lands in a skid register and then the back pipeline freezes;
// the queue then fills and the input ready falls. Results leave in input order.
// Reset clears all valid flags and queue pointers; no clearing pass is needed.
`default_nettype none
module constant_fold_alu #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cfa_in_if.sink    in_if,
  cfa_out_if.source out_if
);
  cfa_pkg::job_t fjob, bjob;
  logic          fvalid, fready, bvalid, bready;

  cfa_front u_front (
    .clk_i, .rst_ni, .in_i(in_if),
    .job_o(fjob), .job_valid_o(fvalid), .job_ready_i(fready)
  );

  cfa_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wdata_i(fjob), .wvalid_i(fvalid), .wready_o(fready),
    .rdata_o(bjob), .rvalid_o(bvalid), .rready_i(bready)
  );

  cfa_back u_back (
    .clk_i, .rst_ni,
    .job_i(bjob), .job_valid_i(bvalid), .job_ready_o(bready),
    .out_o(out_if)
  );
endmodule
`default_nettype wire

### verif/constant_fold_alu_tb.sv
// Testbench for the constant folding ALU: directed and random operations checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module constant_fold_alu_tb;

  typedef struct {
    logic [3:0]  command;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        a_is_const;
    logic        b_is_const;
    logic        a_unsigned;
    logic        result_unsigned;
    logic [1:0]  result_size;
  } op_t;

  typedef struct {
    logic [2:0]  outcome;
    logic [63:0] value;
  } fold_t;

  logic clk_i;
  logic rst_ni;

  cfa_in_if  in_if ();
  cfa_out_if out_if ();

  constant_fold_alu uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  op_t   pending_ops[$];
  fold_t expected_folds[$];
  int    error_count = 0;
  bit    calm_phase = 0;
  bit    drain_request = 0;
  int    hold_request = 0;
  int    send_gap = 0;
  int    recv_gap = 0;
  int    hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] narrow_value(logic [63:0] v, logic [1:0] size, logic uns);
    case (size)
      2'd0: return uns ? {56'd0, v[7:0]} : {{56{v[7]}}, v[7:0]};
      2'd1: return uns ? {48'd0, v[15:0]} : {{48{v[15]}}, v[15:0]};
      2'd2: return uns ? {32'd0, v[31:0]} : {{32{v[31]}}, v[31:0]};
      default: return v;
    endcase
  endfunction

  function automatic fold_t fold_operation(op_t op);
    fold_t res;
    logic [63:0] a, b, v, mag_a, mag_b, q, r;
    logic [5:0] sh;
    a = op.operand_a;
    b = op.operand_b;
    sh = b[5:0];
    v = '0;
    res.outcome = cfa_pkg::OUT_EMIT;
    if (op.command >= 4'd12) begin
      res.outcome = cfa_pkg::OUT_EMIT;
    end else if (op.command == cfa_pkg::CMD_NEG || op.command == cfa_pkg::CMD_NOT) begin
      if (op.a_is_const) begin
        v = (op.command == cfa_pkg::CMD_NEG) ? -a : ~a;
        res.outcome = cfa_pkg::OUT_FOLD;
      end
    end else if (op.a_is_const && op.b_is_const) begin
      res.outcome = cfa_pkg::OUT_FOLD;
      case (op.command)
        cfa_pkg::CMD_ADD: v = a + b;
        cfa_pkg::CMD_SUB: v = a - b;
        cfa_pkg::CMD_MUL: v = a * b;
        cfa_pkg::CMD_DIV, cfa_pkg::CMD_MOD: begin
          if (b == 0) begin
            res.outcome = cfa_pkg::OUT_DIV0;
          end else if (op.result_unsigned) begin
            v = (op.command == cfa_pkg::CMD_DIV) ? a / b : a % b;
          end else begin
            mag_a = a[63] ? -a : a;
            mag_b = b[63] ? -b : b;
            q = mag_a / mag_b;
            r = mag_a % mag_b;
            if (a[63] != b[63]) q = -q;
            if (a[63]) r = -r;
            v = (op.command == cfa_pkg::CMD_DIV) ? q : r;
          end
        end
        cfa_pkg::CMD_AND: v = a & b;
        cfa_pkg::CMD_OR:  v = a | b;
        cfa_pkg::CMD_XOR: v = a ^ b;
        cfa_pkg::CMD_SHL: v = a << sh;
        default: v = op.a_unsigned ? a >> sh : $unsigned($signed(a) >>> sh);
      endcase
    end else if (op.a_is_const) begin
      case (op.command)
        cfa_pkg::CMD_ADD, cfa_pkg::CMD_OR, cfa_pkg::CMD_XOR:
          if (a == 0) res.outcome = cfa_pkg::OUT_PASS_B;
        cfa_pkg::CMD_MUL: if (a == 1) res.outcome = cfa_pkg::OUT_PASS_B;
        cfa_pkg::CMD_DIV, cfa_pkg::CMD_MOD, cfa_pkg::CMD_AND, cfa_pkg::CMD_SHL,
        cfa_pkg::CMD_SHR:
          if (a == 0) res.outcome = cfa_pkg::OUT_PASS_A;
        default: ;
      endcase
    end else if (op.b_is_const) begin
      case (op.command)
        cfa_pkg::CMD_ADD, cfa_pkg::CMD_SUB, cfa_pkg::CMD_OR, cfa_pkg::CMD_XOR,
        cfa_pkg::CMD_SHL, cfa_pkg::CMD_SHR:
          if (b == 0) res.outcome = cfa_pkg::OUT_PASS_A;
        cfa_pkg::CMD_MUL: if (b == 1) res.outcome = cfa_pkg::OUT_PASS_A;
        cfa_pkg::CMD_DIV: begin
          if (b == 0) res.outcome = cfa_pkg::OUT_DIV0;
          else if (b == 1) res.outcome = cfa_pkg::OUT_PASS_A;
        end
        cfa_pkg::CMD_AND: if (b == 0) res.outcome = cfa_pkg::OUT_PASS_B;
        default: ;
      endcase
    end
    res.value = (res.outcome == cfa_pkg::OUT_FOLD) ?
                narrow_value(v, op.result_size, op.result_unsigned) : 64'd0;
    return res;
  endfunction

  function automatic logic [63:0] pick_operand();
    logic [63:0] x;
    case ($urandom_range(0, 9))
      0: x = 64'd0;
      1: x = 64'd1;
      2: x = '1;
      3: x = 64'h8000_0000_0000_0000;
      4: x = 64'h7fff_ffff_ffff_ffff;
      5: x = $urandom_range(0, 70);
      6: x = -$urandom_range(1, 70);
      7: x = {32'd0, $urandom()};
      default: x = {$urandom(), $urandom()};
    endcase
    return x;
  endfunction

  task automatic add_op(logic [3:0] cmd, logic [63:0] a, logic [63:0] b,
                        logic ac, logic bc, logic au, logic ru, logic [1:0] size);
    op_t op;
    op.command = cmd;
    op.operand_a = a;
    op.operand_b = b;
    op.a_is_const = ac;
    op.b_is_const = bc;
    op.a_unsigned = au;
    op.result_unsigned = ru;
    op.result_size = size;
    pending_ops.push_back(op);
  endtask

  // Driver: the predicted result is queued at the transfer itself.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.command <= '0;
      in_if.operand_a <= '0;
      in_if.operand_b <= '0;
      in_if.a_is_const <= 1'b0;
      in_if.b_is_const <= 1'b0;
      in_if.a_unsigned <= 1'b0;
      in_if.result_unsigned <= 1'b0;
      in_if.result_size <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_folds.push_back(fold_operation(pending_ops.pop_front()));
      end
      if (in_if.valid && !in_if.ready) begin
        // Hold the offered item until it transfers.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (drain_request && expected_folds.size() == 0 &&
                   !(in_if.valid && in_if.ready)) begin
        drain_request <= 1'b0;
        in_if.valid <= 1'b0;
      end else if (drain_request || pending_ops.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 19) == 0) begin
        send_gap <= $urandom_range(0, 14);
        in_if.valid <= 1'b0;
      end else begin
        // A transferred item has already left the queue, so the head is the next one.
        automatic op_t nx = pending_ops[0];
        in_if.valid <= 1'b1;
        in_if.command <= nx.command;
        in_if.operand_a <= nx.operand_a;
        in_if.operand_b <= nx.operand_b;
        in_if.a_is_const <= nx.a_is_const;
        in_if.b_is_const <= nx.b_is_const;
        in_if.a_unsigned <= nx.a_unsigned;
        in_if.result_unsigned <= nx.result_unsigned;
        in_if.result_size <= nx.result_size;
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_folds.size() == 0) begin
          $display("%0t: unexpected result outcome=%0d value=%h", $time,
                   out_if.outcome, out_if.value);
          error_count++;
        end else begin
          automatic fold_t exp_f = expected_folds.pop_front();
          if (out_if.outcome !== exp_f.outcome) begin
            $display("%0t: outcome mismatch expected %0d actual %0d", $time,
                     exp_f.outcome, out_if.outcome);
            error_count++;
          end
          if (out_if.value !== exp_f.value) begin
            $display("%0t: value mismatch expected %h actual %h", $time,
                     exp_f.value, out_if.value);
            error_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left <= hold_request;
        hold_request <= 0;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_if.ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 19) == 0) begin
        recv_gap <= $urandom_range(0, 14);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int wait_cycles;
    logic [3:0] cmd;
    rst_ni = 1'b0;
    // Directed items: extremes, every command, special cases.
    add_op(cfa_pkg::CMD_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1, 1, 1, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_SUB, 64'h8000_0000_0000_0000, 64'd1, 1, 1, 1, 1, 2'd3);
    add_op(cfa_pkg::CMD_MUL, '1, '1, 1, 1, 0, 0, 2'd0);
    add_op(cfa_pkg::CMD_MUL, 64'd5, 64'd0, 0, 1, 0, 0, 2'd1);
    add_op(cfa_pkg::CMD_DIV, 64'h8000_0000_0000_0000, '1, 1, 1, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_MOD, 64'h8000_0000_0000_0000, '1, 1, 1, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_DIV, -64'd7, 64'd2, 1, 1, 0, 0, 2'd2);
    add_op(cfa_pkg::CMD_MOD, -64'd7, 64'd2, 1, 1, 0, 0, 2'd1);
    add_op(cfa_pkg::CMD_MOD, -64'd7, 64'd2, 1, 1, 0, 1, 2'd3);
    add_op(cfa_pkg::CMD_DIV, 64'd9, 64'd0, 1, 1, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_MOD, 64'd9, 64'd0, 1, 1, 0, 1, 2'd3);
    add_op(cfa_pkg::CMD_DIV, 64'd9, 64'd0, 0, 1, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_DIV, 64'd9, 64'd1, 0, 1, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_AND, 64'hf0f0, 64'hff00, 1, 1, 0, 1, 2'd0);
    add_op(cfa_pkg::CMD_OR, 64'h0, 64'h1234, 1, 0, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_XOR, '1, 64'h5555, 1, 1, 0, 0, 2'd1);
    add_op(cfa_pkg::CMD_SHL, 64'd1, 64'd127, 1, 1, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_SHR, 64'h8000_0000_0000_0000, 64'd63, 1, 1, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_SHR, 64'h8000_0000_0000_0000, 64'd63, 1, 1, 1, 0, 2'd3);
    add_op(cfa_pkg::CMD_NEG, 64'h8000_0000_0000_0000, 64'd3, 1, 0, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_NOT, 64'h80, 64'd0, 1, 0, 0, 1, 2'd0);
    add_op(cfa_pkg::CMD_SUB, 64'd0, 64'd5, 1, 0, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_AND, 64'd7, 64'd0, 0, 1, 0, 0, 2'd3);
    add_op(4'd13, 64'd1, 64'd1, 1, 1, 0, 0, 2'd3);
    add_op(cfa_pkg::CMD_NEG, 64'd1, 64'd1, 0, 0, 1, 1, 2'd2);
    for (int i = 0; i < 1800; i++) begin
      cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
      add_op(cmd, pick_operand(), pick_operand(), $urandom_range(0, 3) != 0,
             $urandom_range(0, 3) != 0, 1'($urandom()), 1'($urandom()), 2'($urandom()));
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Long receiver hold-off while items keep coming, to fill the block.
    wait (pending_ops.size() < 1700);
    @(posedge clk_i);
    hold_request <= 200;
    // Sender pause until every expected result is back.
    wait (pending_ops.size() < 1000);
    @(posedge clk_i);
    drain_request <= 1'b1;
    wait (pending_ops.size() < 300);
    @(posedge clk_i);
    calm_phase <= 1'b1;
    wait (pending_ops.size() == 0);
    wait (expected_folds.size() == 0);
    wait_cycles = 0;
    while (wait_cycles < 200) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (error_count == 0 && expected_folds.size() == 0) begin
      $display("** constant_fold_alu: PASSED **");
    end else begin
      $display("** constant_fold_alu: FAILED **");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("** constant_fold_alu: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
